// File: src/rod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_pkg
// Shared types and codes for the rebase opcode stream decoder.
// ----------------------------------------------------------------------------
package rod_pkg;

  // Result kinds
  localparam logic [1:0] KIND_RUN    = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Decoder phases
  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_ARG1   = 2'd1;
  localparam logic [1:0] PH_ARG2   = 2'd2;

  // Opcodes (high nibble of an opcode byte)
  localparam logic [3:0] OP_DONE          = 4'd0;
  localparam logic [3:0] OP_SET_TYPE      = 4'd1;
  localparam logic [3:0] OP_SET_SEG_OFF   = 4'd2;
  localparam logic [3:0] OP_ADD_ULEB      = 4'd3;
  localparam logic [3:0] OP_ADD_IMM       = 4'd4;
  localparam logic [3:0] OP_RUN_IMM       = 4'd5;
  localparam logic [3:0] OP_RUN_ULEB      = 4'd6;
  localparam logic [3:0] OP_RUN_ADD_ULEB  = 4'd7;
  localparam logic [3:0] OP_RUN_ULEB_SKIP = 4'd8;

  localparam logic [3:0] TYPE_POINTER = 4'd1;

  // ULEB byte index at which a continuation bit is rejected as overlong
  localparam logic [3:0] LEB_LAST_IDX = 4'd9;

  localparam logic [63:0] PTR_BYTES = 64'd8;

  // Width of the register byte address; its top bit selects the register index
  localparam int ADDR_W = 3;

  // Steps of the shared 32x32 multiplier
  localparam logic [1:0] MUL_IDLE  = 2'd0;
  localparam logic [1:0] MUL_LOLO  = 2'd1;
  localparam logic [1:0] MUL_LOHI  = 2'd2;
  localparam logic [1:0] MUL_HILO  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  seg_index;
    logic [63:0] start_offset;
    logic [63:0] run_count;
    logic [63:0] stride;
    logic        run_invalid;
    logic        last;
  } result_t;

endpackage

// File: src/rebase_opcode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebase_opcode_decoder
// Decodes a rebase opcode byte stream into run descriptors and a verdict.
// ----------------------------------------------------------------------------
// Results of a byte are registered into the result queue. Input: one byte
// per cycle while the multiplier is not busy; a byte that closes a nonzero
// count-with-skip run (opcode 8) before stream end holds the input while
// the shared 32x32 multiplier forms count*stride in three partial products.
// Results sit in a 4-entry queue; a byte is taken while 2 slots are free.
// Reset (synchronous, rst_n low) clears the decoder, queue and segment count.
// ----------------------------------------------------------------------------
module rebase_opcode_decoder (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  input  logic         in_tlast,   // end_of_stream
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] seg_index, [67:4] start_offset, [131:68] run_count,
  // [195:132] stride, [196] run_invalid, [199:197] zero
  output logic [199:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast,  // last
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [rod_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // configuration
  logic [6:0] seg_count_r;

  // decoder state
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  pending_op_r, pending_op_nxt;
  logic [3:0]  rebase_kind_r, rebase_kind_nxt;
  logic [3:0]  cur_segment_r, cur_segment_nxt;
  logic [63:0] cur_offset_r, cur_offset_nxt;
  logic [63:0] leb_accum_r, leb_accum_nxt;
  logic [3:0]  leb_cnt_r, leb_cnt_nxt;
  logic [63:0] first_arg_r, first_arg_nxt;
  logic        saw_invalid_r, saw_invalid_nxt;
  logic        finished_r, finished_nxt;

  // multiplier
  logic [1:0]  mul_step_r, mul_step_nxt;
  logic [63:0] mul_a_r, mul_a_nxt;
  logic [63:0] mul_b_r, mul_b_nxt;
  logic [63:0] prod_r;
  logic        prod_full_r;
  logic        prod_vld_r;
  logic [31:0] mul_x, mul_y;
  logic        mul_go;
  logic        busy;

  // result queue
  rod_pkg::result_t ent_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       push0, push1, pop;
  rod_pkg::result_t res0, res1, run_res, vd_res;

  // per-byte decode
  logic        in_acc;
  logic [3:0]  op, imm;
  logic        eos;
  logic [5:0]  leb_sh;
  logic [63:0] leb_val;
  logic        run_vld, run_bad;
  logic [63:0] run_cnt, run_str;
  logic        vd_vld;
  logic [1:0]  vd_kind;
  logic        clr;

  assign op     = in_tdata[7:4];
  assign imm    = in_tdata[3:0];
  assign eos    = in_tlast;
  assign busy   = (mul_step_r != rod_pkg::MUL_IDLE) || prod_vld_r;
  assign in_tready = !busy && (cnt_r <= 3'd2);
  assign in_acc = in_tvalid && in_tready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {25'd0, seg_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
    end else if (psel && penable && pwrite && !paddr[rod_pkg::ADDR_W-1]) begin
      seg_count_r <= pwdata[6:0];
    end
  end

  // ULEB byte position to bit position
  always_comb begin
    case (leb_cnt_r)
      4'd0:    leb_sh = 6'd0;
      4'd1:    leb_sh = 6'd7;
      4'd2:    leb_sh = 6'd14;
      4'd3:    leb_sh = 6'd21;
      4'd4:    leb_sh = 6'd28;
      4'd5:    leb_sh = 6'd35;
      4'd6:    leb_sh = 6'd42;
      4'd7:    leb_sh = 6'd49;
      4'd8:    leb_sh = 6'd56;
      default: leb_sh = 6'd63;
    endcase
  end

  assign leb_val = leb_accum_r | ({57'd0, in_tdata[6:0]} << leb_sh);

  assign run_bad = (rebase_kind_r != rod_pkg::TYPE_POINTER) ||
                   ({3'd0, cur_segment_r} >= seg_count_r);

  // decode one byte
  always_comb begin
    phase_nxt       = phase_r;
    pending_op_nxt  = pending_op_r;
    rebase_kind_nxt = rebase_kind_r;
    cur_segment_nxt = cur_segment_r;
    cur_offset_nxt  = cur_offset_r;
    leb_accum_nxt   = leb_accum_r;
    leb_cnt_nxt     = leb_cnt_r;
    first_arg_nxt   = first_arg_r;
    saw_invalid_nxt = saw_invalid_r;
    finished_nxt    = finished_r;
    mul_a_nxt       = mul_a_r;
    mul_b_nxt       = mul_b_r;
    mul_go          = 1'b0;
    run_cnt         = '0;
    run_str         = '0;
    vd_vld          = 1'b0;
    vd_kind         = rod_pkg::KIND_ACCEPT;
    clr             = 1'b0;

    if (in_acc) begin
      if (finished_r) begin
        // drop bytes up to the end of the stream
        clr = eos;
      end else begin
        if (phase_r == rod_pkg::PH_OPCODE) begin
          case (op)
            rod_pkg::OP_DONE: begin
              vd_vld  = 1'b1;
              vd_kind = saw_invalid_r ? rod_pkg::KIND_REJECT : rod_pkg::KIND_ACCEPT;
            end
            rod_pkg::OP_SET_TYPE: begin
              rebase_kind_nxt = imm;
            end
            rod_pkg::OP_ADD_IMM: begin
              cur_offset_nxt = cur_offset_r + {57'd0, imm, 3'd0};
            end
            rod_pkg::OP_RUN_IMM: begin
              run_cnt        = {60'd0, imm};
              run_str        = rod_pkg::PTR_BYTES;
              cur_offset_nxt = cur_offset_r + {57'd0, imm, 3'd0};
            end
            rod_pkg::OP_SET_SEG_OFF, rod_pkg::OP_ADD_ULEB, rod_pkg::OP_RUN_ULEB,
            rod_pkg::OP_RUN_ADD_ULEB, rod_pkg::OP_RUN_ULEB_SKIP: begin
              if (op == rod_pkg::OP_SET_SEG_OFF) begin
                cur_segment_nxt = imm;
              end
              phase_nxt      = rod_pkg::PH_ARG1;
              pending_op_nxt = op;
              leb_accum_nxt  = '0;
              leb_cnt_nxt    = '0;
            end
            default: begin
              vd_vld  = 1'b1;
              vd_kind = rod_pkg::KIND_REJECT;
            end
          endcase
        end else if (in_tdata[7]) begin
          // continuation byte: reject on an overlong argument
          if (leb_cnt_r == rod_pkg::LEB_LAST_IDX) begin
            vd_vld  = 1'b1;
            vd_kind = rod_pkg::KIND_REJECT;
          end else begin
            leb_accum_nxt = leb_val;
            leb_cnt_nxt   = leb_cnt_r + 4'd1;
          end
        end else begin
          // argument complete
          leb_accum_nxt = '0;
          leb_cnt_nxt   = '0;
          phase_nxt     = rod_pkg::PH_OPCODE;
          if (phase_r == rod_pkg::PH_ARG2) begin
            run_cnt   = first_arg_r;
            run_str   = leb_val + rod_pkg::PTR_BYTES;
            mul_a_nxt = first_arg_r;
            mul_b_nxt = leb_val + rod_pkg::PTR_BYTES;
            mul_go    = (first_arg_r != 64'd0) && !eos;
          end else begin
            case (pending_op_r)
              rod_pkg::OP_SET_SEG_OFF: begin
                cur_offset_nxt = leb_val;
              end
              rod_pkg::OP_ADD_ULEB: begin
                cur_offset_nxt = cur_offset_r + leb_val;
              end
              rod_pkg::OP_RUN_ULEB: begin
                run_cnt        = leb_val;
                run_str        = rod_pkg::PTR_BYTES;
                cur_offset_nxt = cur_offset_r + {leb_val[60:0], 3'd0};
              end
              rod_pkg::OP_RUN_ADD_ULEB: begin
                run_cnt        = 64'd1;
                run_str        = leb_val + rod_pkg::PTR_BYTES;
                cur_offset_nxt = cur_offset_r + leb_val + rod_pkg::PTR_BYTES;
              end
              rod_pkg::OP_RUN_ULEB_SKIP: begin
                first_arg_nxt = leb_val;
                phase_nxt     = rod_pkg::PH_ARG2;
              end
              default: begin
              end
            endcase
          end
        end

        // flag a bad run
        if ((run_cnt != 64'd0) && run_bad) begin
          saw_invalid_nxt = 1'b1;
        end

        // close the stream at its last byte
        if (!vd_vld && eos) begin
          vd_vld  = 1'b1;
          vd_kind = ((phase_nxt != rod_pkg::PH_OPCODE) || saw_invalid_nxt) ?
                    rod_pkg::KIND_REJECT : rod_pkg::KIND_ACCEPT;
        end
        if (vd_vld) begin
          if (eos) begin
            clr = 1'b1;
          end else begin
            finished_nxt = 1'b1;
          end
        end
      end

      // start a fresh stream
      if (clr) begin
        phase_nxt       = rod_pkg::PH_OPCODE;
        pending_op_nxt  = '0;
        rebase_kind_nxt = '0;
        cur_segment_nxt = '0;
        cur_offset_nxt  = '0;
        leb_accum_nxt   = '0;
        leb_cnt_nxt     = '0;
        first_arg_nxt   = '0;
        saw_invalid_nxt = 1'b0;
        finished_nxt    = 1'b0;
        mul_go          = 1'b0;
      end
    end else if (prod_vld_r) begin
      // fold a partial product into the offset
      cur_offset_nxt = cur_offset_r + (prod_full_r ? prod_r : {prod_r[31:0], 32'd0});
    end
  end

  assign run_vld = in_acc && !finished_r && (run_cnt != 64'd0);

  // multiplier operand selection and stepping
  always_comb begin
    case (mul_step_r)
      rod_pkg::MUL_LOLO: begin
        mul_x = mul_a_r[31:0];
        mul_y = mul_b_r[31:0];
      end
      rod_pkg::MUL_LOHI: begin
        mul_x = mul_a_r[31:0];
        mul_y = mul_b_r[63:32];
      end
      rod_pkg::MUL_HILO: begin
        mul_x = mul_a_r[63:32];
        mul_y = mul_b_r[31:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase

    if (mul_go) begin
      mul_step_nxt = rod_pkg::MUL_LOLO;
    end else if (mul_step_r == rod_pkg::MUL_HILO) begin
      mul_step_nxt = rod_pkg::MUL_IDLE;
    end else if (mul_step_r != rod_pkg::MUL_IDLE) begin
      mul_step_nxt = mul_step_r + 2'd1;
    end else begin
      mul_step_nxt = rod_pkg::MUL_IDLE;
    end
  end

  // hold the partial product
  always_ff @(posedge clk) begin
    prod_r      <= mul_x * mul_y;
    prod_full_r <= (mul_step_r == rod_pkg::MUL_LOLO);
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rod_pkg::PH_OPCODE;
      pending_op_r  <= '0;
      rebase_kind_r <= '0;
      cur_segment_r <= '0;
      cur_offset_r  <= '0;
      leb_accum_r   <= '0;
      leb_cnt_r     <= '0;
      first_arg_r   <= '0;
      saw_invalid_r <= 1'b0;
      finished_r    <= 1'b0;
      mul_step_r    <= rod_pkg::MUL_IDLE;
      prod_vld_r    <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pending_op_r  <= pending_op_nxt;
      rebase_kind_r <= rebase_kind_nxt;
      cur_segment_r <= cur_segment_nxt;
      cur_offset_r  <= cur_offset_nxt;
      leb_accum_r   <= leb_accum_nxt;
      leb_cnt_r     <= leb_cnt_nxt;
      first_arg_r   <= first_arg_nxt;
      saw_invalid_r <= saw_invalid_nxt;
      finished_r    <= finished_nxt;
      mul_step_r    <= mul_step_nxt;
      prod_vld_r    <= (mul_step_r != rod_pkg::MUL_IDLE);
    end
  end

  // build the results of this byte: run first, then verdict
  always_comb begin
    run_res.kind         = rod_pkg::KIND_RUN;
    run_res.seg_index    = cur_segment_r;
    run_res.start_offset = cur_offset_r;
    run_res.run_count    = run_cnt;
    run_res.stride       = run_str;
    run_res.run_invalid  = run_bad;
    run_res.last         = 1'b0;

    vd_res.kind          = vd_kind;
    vd_res.seg_index     = '0;
    vd_res.start_offset  = '0;
    vd_res.run_count     = '0;
    vd_res.stride        = '0;
    vd_res.run_invalid   = 1'b0;
    vd_res.last          = 1'b1;

    res0  = run_vld ? run_res : vd_res;
    res1  = vd_res;
    push0 = run_vld || vd_vld;
    push1 = run_vld && vd_vld;
  end

  // result queue
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push0) begin
      ent_r[wr_ptr_r] <= res0;
    end
    if (push1) begin
      ent_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + {1'b0, push0} + {1'b0, push1};
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {2'd0, push0} + {2'd0, push1} - {2'd0, pop};
    end
  end

  // drive the result channel
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = ent_r[rd_ptr_r].kind;
  assign out_tlast  = ent_r[rd_ptr_r].last;
  assign out_tdata  = {3'd0,
                       ent_r[rd_ptr_r].run_invalid,
                       ent_r[rd_ptr_r].stride,
                       ent_r[rd_ptr_r].run_count,
                       ent_r[rd_ptr_r].start_offset,
                       ent_r[rd_ptr_r].seg_index};

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rebase opcode stream decoder. Byte streams,
// directed ones first and then random well-formed and broken ones, are fed
// through a gap-inserting driver. Every accepted byte is decoded by an
// in-bench predictor. A stalling monitor compares each result transaction
// field by field with the oldest predicted run or verdict. The segment count
// register is rewritten between phases while the decoder is idle.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } byte_item_t;

  localparam logic [rod_pkg::ADDR_W-1:0] REG_SEG_COUNT = '0;

  // Byte values used to build streams
  localparam logic [7:0] OPB_DONE      = {rod_pkg::OP_DONE, 4'h0};
  localparam logic [7:0] OPB_TYPE_PTR  = {rod_pkg::OP_SET_TYPE, rod_pkg::TYPE_POINTER};
  localparam logic [7:0] OPB_UNKNOWN   = 8'h9a;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;     // [7:0] stream_byte
  logic         in_tlast = 1'b0;   // end_of_stream
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [3:0] seg_index, [67:4] start_offset, [131:68] run_count,
  // [195:132] stride, [196] run_invalid, [199:197] zero
  logic [199:0] out_tdata;
  logic [1:0]   out_tuser;         // [1:0] kind
  logic         out_tlast;         // last
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [rod_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  rebase_opcode_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shared bench state
  byte_item_t        byte_backlog[$];
  logic [7:0]        stream_buf[$];
  rod_pkg::result_t  descriptors_due[$];
  int          err_count = 0;
  int          items_queued = 0;
  int          bytes_taken = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  bit          no_idle = 1'b0;
  logic        hold_off = 1'b0;

  // Predictor state
  logic [6:0]  seg_limit = '0;
  logic [1:0]  dec_phase;
  logic [3:0]  pend_op;
  logic [3:0]  ptr_type;
  logic [3:0]  cur_seg;
  logic [63:0] cur_off;
  logic [63:0] leb_acc;
  logic [6:0]  leb_sh;
  logic [63:0] skip_count;
  logic        any_invalid;
  logic        stream_closed;

  task automatic note_error(input string msg);
    err_count++;
    $display("tb: mismatch: %s", msg);
  endtask

  task automatic restart_stream();
    dec_phase = rod_pkg::PH_OPCODE;
    pend_op = '0;
    ptr_type = '0;
    cur_seg = '0;
    cur_off = '0;
    leb_acc = '0;
    leb_sh = '0;
    skip_count = '0;
    any_invalid = 1'b0;
    stream_closed = 1'b0;
  endtask

  // Queue a run descriptor; an empty run produces nothing
  task automatic emit_run(input logic [63:0] count, input logic [63:0] stride);
    rod_pkg::result_t r;
    if (count != 0) begin
      r = '0;
      r.kind = rod_pkg::KIND_RUN;
      r.seg_index = cur_seg;
      r.start_offset = cur_off;
      r.run_count = count;
      r.stride = stride;
      r.run_invalid = (ptr_type != rod_pkg::TYPE_POINTER) ||
                      ({3'b000, cur_seg} >= seg_limit);
      if (r.run_invalid) any_invalid = 1'b1;
      descriptors_due.push_back(r);
      cur_off = cur_off + count * stride;
    end
  endtask

  // Advance the predicted decoder by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [3:0]  op;
    logic [3:0]  imm;
    logic        has_verdict;
    logic [1:0]  verdict;
    logic [63:0] v;
    rod_pkg::result_t r;
    op = b[7:4];
    imm = b[3:0];
    has_verdict = 1'b0;
    verdict = rod_pkg::KIND_ACCEPT;
    if (stream_closed) begin
      // drop everything until the end-of-stream mark
      if (eos) restart_stream();
    end else begin
      if (dec_phase == rod_pkg::PH_OPCODE) begin
        case (op)
          rod_pkg::OP_DONE: begin
            has_verdict = 1'b1;
            verdict = any_invalid ? rod_pkg::KIND_REJECT : rod_pkg::KIND_ACCEPT;
          end
          rod_pkg::OP_SET_TYPE: ptr_type = imm;
          rod_pkg::OP_ADD_IMM: cur_off = cur_off + {57'd0, imm, 3'b000};
          rod_pkg::OP_RUN_IMM: emit_run({60'd0, imm}, rod_pkg::PTR_BYTES);
          rod_pkg::OP_SET_SEG_OFF, rod_pkg::OP_ADD_ULEB, rod_pkg::OP_RUN_ULEB,
          rod_pkg::OP_RUN_ADD_ULEB, rod_pkg::OP_RUN_ULEB_SKIP: begin
            if (op == rod_pkg::OP_SET_SEG_OFF) cur_seg = imm;
            dec_phase = rod_pkg::PH_ARG1;
            pend_op = op;
            leb_acc = '0;
            leb_sh = '0;
          end
          default: begin
            has_verdict = 1'b1;
            verdict = rod_pkg::KIND_REJECT;
          end
        endcase
      end else begin
        // gather one ULEB128 group; bits above 63 fall off
        leb_acc = leb_acc | (64'(b[6:0]) << leb_sh[5:0]);
        if (b[7]) begin
          leb_sh = leb_sh + 7'd7;
          if (leb_sh >= 7'd64) begin
            has_verdict = 1'b1;
            verdict = rod_pkg::KIND_REJECT;
          end
        end else begin
          v = leb_acc;
          leb_acc = '0;
          leb_sh = '0;
          if (dec_phase == rod_pkg::PH_ARG2) begin
            emit_run(skip_count, rod_pkg::PTR_BYTES + v);
            dec_phase = rod_pkg::PH_OPCODE;
          end else begin
            dec_phase = rod_pkg::PH_OPCODE;
            case (pend_op)
              rod_pkg::OP_SET_SEG_OFF: cur_off = v;
              rod_pkg::OP_ADD_ULEB: cur_off = cur_off + v;
              rod_pkg::OP_RUN_ULEB: emit_run(v, rod_pkg::PTR_BYTES);
              rod_pkg::OP_RUN_ADD_ULEB: emit_run(64'd1, rod_pkg::PTR_BYTES + v);
              rod_pkg::OP_RUN_ULEB_SKIP: begin
                skip_count = v;
                dec_phase = rod_pkg::PH_ARG2;
              end
              default: ;
            endcase
          end
        end
      end

      if (!has_verdict && eos) begin
        has_verdict = 1'b1;
        verdict = (dec_phase != rod_pkg::PH_OPCODE || any_invalid) ?
                  rod_pkg::KIND_REJECT : rod_pkg::KIND_ACCEPT;
      end

      if (has_verdict) begin
        r = '0;
        r.kind = verdict;
        r.last = 1'b1;
        descriptors_due.push_back(r);
        if (eos) restart_stream();
        else stream_closed = 1'b1;
      end
    end
  endtask

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Driver: hold the offered byte until taken, then predict and advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(byte_backlog[0].data, byte_backlog[0].eos);
        void'(byte_backlog.pop_front());
        bytes_taken++;
        tx_gap = pick_gap();
      end
      if (in_tvalid && !in_tready) begin
        // hold
      end else if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_backlog.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= byte_backlog[0].data;
        in_tlast <= byte_backlog[0].eos;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) note_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Monitor: check each result transaction, then choose the next ready
  always @(posedge clk) begin
    rod_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (descriptors_due.size() == 0) begin
        note_error($sformatf("unexpected result kind %0d", out_tuser));
      end else begin
        want = descriptors_due.pop_front();
        cmp_field("kind", 64'(out_tuser), 64'(want.kind));
        cmp_field("last", 64'(out_tlast), 64'(want.last));
        cmp_field("seg_index", 64'(out_tdata[3:0]), 64'(want.seg_index));
        cmp_field("start_offset", out_tdata[67:4], want.start_offset);
        cmp_field("run_count", out_tdata[131:68], want.run_count);
        cmp_field("stride", out_tdata[195:132], want.stride);
        cmp_field("run_invalid", 64'(out_tdata[196]), 64'(want.run_invalid));
      end
    end
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      rx_stall = pick_gap();
      out_tready <= (rx_stall == 0);
    end
  end

  // Long receiver hold-off so the result queue fills and the input stalls
  initial begin
    wait (bytes_taken >= 500);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("tb: done, errors");
    $finish;
  end

  task automatic add_b(input logic [7:0] b);
    stream_buf.push_back(b);
  endtask

  // Append a ULEB128 value, sometimes padded, with junk above bit 63
  task automatic add_uleb(input logic [63:0] value);
    int nb;
    logic [63:0] rest;
    logic [7:0] b;
    nb = 1;
    rest = value >> 7;
    while (rest != 0) begin
      nb++;
      rest = rest >> 7;
    end
    if ($urandom_range(0, 7) == 0) nb += $urandom_range(1, 3);
    if (nb > 10) nb = 10;
    rest = value;
    for (int i = 0; i < nb; i++) begin
      b = {1'b0, rest[6:0]};
      rest = rest >> 7;
      if (i == 9) b[6:1] = 6'($urandom);
      if (i != nb - 1) b[7] = 1'b1;
      stream_buf.push_back(b);
    end
  endtask

  // Move the built stream to the backlog, marking its last byte
  task automatic flush_stream();
    for (int i = 0; i < stream_buf.size(); i++)
      byte_backlog.push_back('{data: stream_buf[i], eos: (i == stream_buf.size() - 1)});
    items_queued += stream_buf.size();
    stream_buf.delete();
  endtask

  function automatic logic [63:0] pick_arg();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 64'($urandom_range(0, 40));
    if (r < 7) return 64'($urandom_range(0, 20000));
    if (r == 7) return {32'd0, $urandom};
    if (r == 8) return {$urandom, $urandom};
    return ~64'($urandom_range(0, 64));
  endfunction

  // Build one mostly well-formed stream with random content and ending
  task automatic random_stream();
    int nops;
    int unsigned r;
    logic [3:0] nib;
    nops = $urandom_range(1, 10);
    if ($urandom_range(0, 9) != 0) add_b(OPB_TYPE_PTR);
    for (int i = 0; i < nops; i++) begin
      r = $urandom_range(0, 99);
      nib = 4'($urandom);
      if (r < 8) begin
        add_b({rod_pkg::OP_SET_TYPE,
               ($urandom_range(0, 3) == 0) ? nib : rod_pkg::TYPE_POINTER});
      end else if (r < 22) begin
        add_b({rod_pkg::OP_SET_SEG_OFF, nib});
        add_uleb(pick_arg());
      end else if (r < 32) begin
        add_b({rod_pkg::OP_ADD_ULEB, 4'h0});
        add_uleb(pick_arg());
      end else if (r < 42) begin
        add_b({rod_pkg::OP_ADD_IMM, nib});
      end else if (r < 56) begin
        add_b({rod_pkg::OP_RUN_IMM, nib});
      end else if (r < 68) begin
        add_b({rod_pkg::OP_RUN_ULEB, 4'h0});
        add_uleb(pick_arg());
      end else if (r < 80) begin
        add_b({rod_pkg::OP_RUN_ADD_ULEB, 4'h0});
        add_uleb(pick_arg());
      end else if (r < 95) begin
        add_b({rod_pkg::OP_RUN_ULEB_SKIP, 4'h0});
        add_uleb(pick_arg());
        add_uleb(pick_arg());
      end else begin
        add_b(8'($urandom));
      end
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      // cut off inside an argument
      add_b({rod_pkg::OP_RUN_ULEB, 4'h0});
      add_b(8'h80 | 8'($urandom));
    end else if (r == 1) begin
      // overlong argument
      add_b({rod_pkg::OP_ADD_ULEB, 4'h0});
      repeat (10) add_b(8'h80 | 8'($urandom));
      repeat ($urandom_range(0, 2)) add_b(8'($urandom));
    end else if (r == 2) begin
      add_b({4'($urandom_range(9, 15)), 4'($urandom)});
      repeat ($urandom_range(0, 2)) add_b(8'($urandom));
    end else if (r == 3) begin
      // no closing opcode
    end else begin
      add_b({rod_pkg::OP_DONE, 4'($urandom)});
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) add_b(8'($urandom));
    end
  endtask

  task automatic noise_stream();
    repeat ($urandom_range(1, 20)) add_b(8'($urandom));
  endtask

  // Write the segment count and read it back
  task automatic write_seg_count(input logic [6:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SEG_COUNT;
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seg_limit = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cmp_field("seg count readback", 64'(prdata), 64'(value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait for the decoder to drain, then let any late work settle
  task automatic wait_idle();
    while (byte_backlog.size() != 0 || in_tvalid || descriptors_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int target;
    logic [6:0] setting;
    restart_stream();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset segment count of zero: every run is out of range
    @(negedge clk);
    add_b({rod_pkg::OP_RUN_IMM, 4'h1});
    add_b(OPB_DONE);
    flush_stream();
    wait_idle();
    write_seg_count(7'd64);

    // Every operation but done, empty run, run and verdict on the marked byte
    @(negedge clk);
    add_b(OPB_TYPE_PTR);
    add_b({rod_pkg::OP_SET_SEG_OFF, 4'hf}); add_b(8'h7f);
    add_b({rod_pkg::OP_RUN_IMM, 4'hf});
    add_b({rod_pkg::OP_ADD_IMM, 4'hf});
    add_b({rod_pkg::OP_ADD_ULEB, 4'h0}); add_b(8'h05);
    add_b({rod_pkg::OP_RUN_ULEB, 4'h0}); add_b(8'h02);
    add_b({rod_pkg::OP_RUN_ADD_ULEB, 4'h0}); add_b(8'h88); add_b(8'h01);
    add_b({rod_pkg::OP_RUN_ULEB_SKIP, 4'h0}); add_b(8'h03); add_b(8'h10);
    add_b({rod_pkg::OP_RUN_IMM, 4'h0});
    add_b({rod_pkg::OP_SET_TYPE, 4'h2});
    add_b({rod_pkg::OP_RUN_IMM, 4'h1});
    flush_stream();
    // Unknown opcode, then ignored bytes up to the mark
    add_b(OPB_UNKNOWN);
    add_b(8'h55);
    flush_stream();
    // Overlong argument
    add_b({rod_pkg::OP_ADD_ULEB, 4'h0});
    repeat (10) add_b(8'hff);
    add_b(8'h01);
    flush_stream();
    // Stream ends inside an argument
    add_b({rod_pkg::OP_RUN_ULEB, 4'h0}); add_b(8'h81);
    flush_stream();
    // Stream ends without a closing opcode
    add_b({rod_pkg::OP_RUN_IMM, 4'hf});
    flush_stream();

    // Random phases over several segment counts
    for (int k = 0; k < 6; k++) begin
      wait_idle();
      case (k)
        0: setting = 7'd64;
        1: setting = 7'd0;
        2: setting = 7'd16;
        3: setting = 7'd1;
        4: setting = 7'd15;
        default: setting = 7'($urandom_range(2, 63));
      endcase
      write_seg_count(setting);
      @(negedge clk);
      no_idle = (k == 3);
      target = items_queued + 220;
      while (items_queued < target) begin
        if ($urandom_range(0, 9) == 0) noise_stream();
        else random_stream();
        flush_stream();
        while (byte_backlog.size() > 64) @(negedge clk);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: rebase_opcode_decoder.f
src/rod_pkg.sv
src/rebase_opcode_decoder.sv
dv/tb.sv
